### rtl/qfem_pkg.sv
// Shared constants and types of the q-gram filtered exact match counter.
`default_nettype none
package qfem_pkg;
    localparam int BYTE_W          = 8;
    localparam int ALPHABET        = 256;
    localparam int GRAM_W          = 2 * BYTE_W;
    localparam int FLT_DEPTH       = 1 << GRAM_W;
    localparam int COUNT_W         = 13;
    localparam int CFG_W           = 5;
    localparam int GB_MIN          = 9;
    localparam int GB_MAX          = 16;
    localparam int GB_RESET        = 16;
    localparam int DEF_MAX_PATTERN = 64;
    localparam int DEF_MAX_TEXT    = 4096;

    // access to the gram filter and the shift table
    typedef struct packed {
        logic              flt_we;
        logic              flt_wdata;
        logic [GRAM_W-1:0] flt_addr;
        logic              sh_we;
        logic [BYTE_W-1:0] sh_addr;
    } tbl_req_t;
endpackage
`default_nettype wire

### rtl/qfem_text_store.sv
// Text byte memory with range-checked registered read.
`default_nettype none
module qfem_text_store
    import qfem_pkg::*;
#(
    parameter int MAX_TEXT = DEF_MAX_TEXT,
    parameter int TADDR_W  = $clog2(MAX_TEXT),
    parameter int TLEN_W   = $clog2(MAX_TEXT + 1),
    parameter int POS_W    = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    we,
    input  wire logic [TADDR_W-1:0]      waddr,
    input  wire logic [BYTE_W-1:0]       wdata,
    input  wire logic signed [POS_W-1:0] raddr,
    input  wire logic [TLEN_W-1:0]       tlen,
    output      logic [BYTE_W-1:0]       rdata
);
    logic [BYTE_W-1:0] mem [MAX_TEXT];
    logic [BYTE_W-1:0] raw_reg;
    logic              ok_reg;
    logic              in_range;

    assign in_range = !raddr[POS_W-1] &&
                      (raddr < signed'({{(POS_W - TLEN_W){1'b0}}, tlen}));

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        raw_reg <= mem[raddr[TADDR_W-1:0]];
        ok_reg  <= in_range;
    end

    // bytes outside the text read as zero
    assign rdata = ok_reg ? raw_reg : '0;
endmodule
`default_nettype wire

### rtl/qfem_tables.sv
// Gram filter bit memory and last-occurrence shift table memory.
`default_nettype none
module qfem_tables
    import qfem_pkg::*;
#(
    parameter int SH_W = 7
) (
    input  wire logic            aclk,
    input  wire tbl_req_t        req,
    input  wire logic [SH_W-1:0] sh_wdata,
    output      logic            flt_rdata,
    output      logic [SH_W-1:0] sh_rdata
);
    logic            flt_mem [FLT_DEPTH];
    logic [SH_W-1:0] sh_mem  [ALPHABET];

    always_ff @(posedge aclk) begin
        if (req.flt_we) begin
            flt_mem[req.flt_addr] <= req.flt_wdata;
        end
        flt_rdata <= flt_mem[req.flt_addr];
    end

    always_ff @(posedge aclk) begin
        if (req.sh_we) begin
            sh_mem[req.sh_addr] <= sh_wdata;
        end
        sh_rdata <= sh_mem[req.sh_addr];
    end
endmodule
`default_nettype wire

### rtl/qgram_filtered_exact_match_count.sv
// Exact match counter: loads pattern and text bytes, then runs a q-gram filtered scan.
// Usage:
//   s_ channel: one byte per item. s_tuser = 1 marks a pattern byte, 0 a text byte;
//   s_tlast on a text byte starts the search. Loads accept one item per cycle while idle.
//   cfg channel: writes gram_bits (saturated to 9..16 at use); write only while idle.
//   m_ channel: one item per search: match count and overflow flag.
// Steps of a search, with k = gram_bits, m = pattern length:
//   a length check, a sweep clearing the first 2^k gram filter entries (shift table
//   set to m+1 in the same sweep), a load of pattern grams and shifts, a pass that
//   marks the grams ending in the last pattern byte, then the scan: scan steps, gram
//   lookups, candidate decisions, byte verification, shift lookups, the result.
//   The text memory has a single read port, so each scan step reads bytes serially.
// s_tready is low from the last text byte until the result is in the output
// register. The result register holds while m_tready is low; loads may continue,
// but the next search finishes only after the earlier result is taken.
// Reset clears lengths, overflow flag and gram_bits (to 16); the tables need no
// reset since every search rebuilds them.
`default_nettype none
module qgram_filtered_exact_match_count
    import qfem_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int MAX_TEXT    = DEF_MAX_TEXT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output      logic             s_tready,
    input  wire logic [7:0]       s_tdata,   // [7:0] byte_value
    input  wire logic             s_tuser,   // [0] is_pattern
    input  wire logic             s_tlast,
    output      logic             m_tvalid,
    input  wire logic             m_tready,
    output      logic [15:0]      m_tdata,   // [12:0] match_count, [13] overflow
    input  wire logic             cfg_valid,
    output      logic             cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);
    localparam int PADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PLEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int TADDR_W = $clog2(MAX_TEXT);
    localparam int TLEN_W  = $clog2(MAX_TEXT + 1);
    localparam int POS_W   = $clog2(MAX_TEXT + 2 * MAX_PATTERN + 2) + 1;
    localparam int SH_W    = $clog2(MAX_PATTERN + 2);
    localparam int IDX_W   = GRAM_W + 1;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_CHECK = 5'd1;
    localparam logic [4:0] ST_CLEAR = 5'd2;
    localparam logic [4:0] ST_PRD   = 5'd3;
    localparam logic [4:0] ST_PWR   = 5'd4;
    localparam logic [4:0] ST_LASTB = 5'd5;
    localparam logic [4:0] ST_LOOP  = 5'd6;
    localparam logic [4:0] ST_G0    = 5'd7;
    localparam logic [4:0] ST_G1    = 5'd8;
    localparam logic [4:0] ST_G2    = 5'd9;
    localparam logic [4:0] ST_G3    = 5'd10;
    localparam logic [4:0] ST_D     = 5'd11;
    localparam logic [4:0] ST_V0    = 5'd12;
    localparam logic [4:0] ST_V1    = 5'd13;
    localparam logic [4:0] ST_H0    = 5'd14;
    localparam logic [4:0] ST_H1    = 5'd15;
    localparam logic [4:0] ST_H2    = 5'd16;
    localparam logic [4:0] ST_DONE  = 5'd17;

    localparam logic [1:0] RET_A = 2'd0;  // gram at window start
    localparam logic [1:0] RET_B = 2'd1;  // gram one pattern length back
    localparam logic [1:0] RET_E = 2'd2;  // second gram of the window

    logic [4:0]              state_reg, state_next;
    logic [CFG_W-1:0]        gb_reg, gb_next;
    logic [PLEN_W-1:0]       plen_reg, plen_next;
    logic [TLEN_W-1:0]       tlen_reg, tlen_next;
    logic                    ovf_reg, ovf_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic signed [POS_W-1:0] gpos_reg, gpos_next;
    logic [1:0]              ret_reg, ret_next;
    logic [PLEN_W-1:0]       j_reg, j_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [BYTE_W-1:0]       lb_reg, lb_next;
    logic [BYTE_W-1:0]       prev_reg, prev_next;
    logic [BYTE_W-1:0]       lo_reg, lo_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [COUNT_W-1:0]      out_count_reg, out_count_next;
    logic                    out_ovf_reg, out_ovf_next;
    logic                    m_valid_reg, m_valid_next;

    logic [BYTE_W-1:0]       pat_mem [MAX_PATTERN];
    logic [BYTE_W-1:0]       pat_rdata;
    logic                    pat_we;

    logic                    s_acc;
    logic [CFG_W-1:0]        k_eff;
    logic [GRAM_W-1:0]       mask;
    logic signed [POS_W-1:0] m_s, n_s, j_s, pm;
    logic signed [POS_W-1:0] t_raddr;
    logic [BYTE_W-1:0]       t_rdata;
    logic                    t_we;
    tbl_req_t                req;
    logic [SH_W-1:0]         sh_wdata;
    logic                    flt_rdata;
    logic [SH_W-1:0]         sh_rdata;
    logic [PLEN_W-1:0]       mm1;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {2'b00, out_ovf_reg, out_count_reg};

    always_comb begin
        priority if (gb_reg < CFG_W'(GB_MIN)) k_eff = CFG_W'(GB_MIN);
        else if (gb_reg > CFG_W'(GB_MAX))     k_eff = CFG_W'(GB_MAX);
        else                                  k_eff = gb_reg;
    end
    assign mask = GRAM_W'({GRAM_W{1'b1}} >> (CFG_W'(GRAM_W) - k_eff));

    assign m_s = signed'({{(POS_W - PLEN_W){1'b0}}, plen_reg});
    assign n_s = signed'({{(POS_W - TLEN_W){1'b0}}, tlen_reg});
    assign j_s = signed'({{(POS_W - PLEN_W){1'b0}}, j_reg});
    assign pm  = pos_reg - m_s;
    assign mm1 = plen_reg - PLEN_W'(1);

    // pattern store
    assign pat_we = s_acc && s_tuser && (plen_reg < PLEN_W'(MAX_PATTERN));
    always_ff @(posedge aclk) begin
        if (pat_we) begin
            pat_mem[plen_reg[PADDR_W-1:0]] <= s_tdata;
        end
        pat_rdata <= pat_mem[j_reg[PADDR_W-1:0]];
    end

    assign t_we = s_acc && !s_tuser && (tlen_reg < TLEN_W'(MAX_TEXT));

    always_comb begin
        unique case (state_reg)
            ST_G1:   t_raddr = gpos_reg + POS_W'(1);
            ST_V0:   t_raddr = pos_reg + j_s;
            ST_H0:   t_raddr = pos_reg - POS_W'(1);
            default: t_raddr = gpos_reg;
        endcase
    end

    qfem_text_store #(
        .MAX_TEXT (MAX_TEXT),
        .TADDR_W  (TADDR_W),
        .TLEN_W   (TLEN_W),
        .POS_W    (POS_W)
    ) u_text (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (tlen_reg[TADDR_W-1:0]),
        .wdata (s_tdata),
        .raddr (t_raddr),
        .tlen  (tlen_reg),
        .rdata (t_rdata)
    );

    always_comb begin
        req       = '0;
        sh_wdata  = SH_W'(plen_reg) + SH_W'(1);
        unique case (state_reg)
            ST_CLEAR: begin
                req.flt_we   = 1'b1;
                req.flt_addr = idx_reg[GRAM_W-1:0];
                req.sh_we    = (idx_reg[IDX_W-1:BYTE_W] == '0);
                req.sh_addr  = idx_reg[BYTE_W-1:0];
            end
            ST_PWR: begin
                req.sh_we     = 1'b1;
                req.sh_addr   = pat_rdata;
                sh_wdata      = SH_W'(j_reg) + SH_W'(1);
                req.flt_we    = (j_reg != mm1);
                req.flt_wdata = 1'b1;
                req.flt_addr  = {prev_reg, pat_rdata} & mask;
            end
            ST_LASTB: begin
                req.flt_we    = 1'b1;
                req.flt_wdata = 1'b1;
                req.flt_addr  = {idx_reg[BYTE_W-1:0], lb_reg};
            end
            ST_G2:   req.flt_addr = {t_rdata, lo_reg} & mask;
            ST_H1:   req.sh_addr  = t_rdata;
            default: ;
        endcase
    end

    qfem_tables #(
        .SH_W (SH_W)
    ) u_tables (
        .aclk      (aclk),
        .req       (req),
        .sh_wdata  (sh_wdata),
        .flt_rdata (flt_rdata),
        .sh_rdata  (sh_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        gb_next        = gb_reg;
        plen_next      = plen_reg;
        tlen_next      = tlen_reg;
        ovf_next       = ovf_reg;
        pos_next       = pos_reg;
        gpos_next      = gpos_reg;
        ret_next       = ret_reg;
        j_next         = j_reg;
        idx_next       = idx_reg;
        lb_next        = lb_reg;
        prev_next      = prev_reg;
        lo_next        = lo_reg;
        count_next     = count_reg;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        if (cfg_valid) begin
            gb_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser) begin
                        if (pat_we) plen_next = plen_reg + PLEN_W'(1);
                        else        ovf_next  = 1'b1;
                    end else begin
                        if (t_we) tlen_next = tlen_reg + TLEN_W'(1);
                        else      ovf_next  = 1'b1;
                        if (s_tlast) state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                count_next = '0;
                idx_next   = '0;
                if (plen_reg == '0 || n_s < m_s) state_next = ST_DONE;
                else                             state_next = ST_CLEAR;
            end
            ST_CLEAR: begin
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg[GRAM_W-1:0] == mask) begin
                    j_next     = mm1;
                    state_next = ST_PRD;
                end
            end
            ST_PRD: state_next = ST_PWR;
            ST_PWR: begin
                prev_next = pat_rdata;
                if (j_reg == mm1) lb_next = pat_rdata;
                if (j_reg == '0) begin
                    idx_next   = '0;
                    state_next = ST_LASTB;
                end else begin
                    j_next     = j_reg - PLEN_W'(1);
                    state_next = ST_PRD;
                end
            end
            ST_LASTB: begin
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg[BYTE_W-1:0] == mask[GRAM_W-1:BYTE_W]) begin
                    pos_next   = n_s - m_s;
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP: begin
                if (pos_reg[POS_W-1]) begin
                    state_next = ST_DONE;
                end else begin
                    gpos_next  = pos_reg;
                    ret_next   = RET_A;
                    state_next = ST_G0;
                end
            end
            ST_G0: state_next = ST_G1;
            ST_G1: state_next = ST_G2;
            ST_G2: begin
                lo_next    = lo_reg;
                state_next = ST_G3;
            end
            ST_G3: begin
                unique case (ret_reg)
                    RET_A: begin
                        if (flt_rdata) begin
                            state_next = ST_D;
                        end else begin
                            gpos_next  = pm;
                            ret_next   = RET_B;
                            state_next = ST_G0;
                        end
                    end
                    RET_B: begin
                        if (flt_rdata) begin
                            pos_next   = pm;
                            state_next = pm[POS_W-1] ? ST_DONE : ST_D;
                        end else begin
                            pos_next   = pm - m_s;
                            state_next = ST_LOOP;
                        end
                    end
                    RET_E: begin
                        if (flt_rdata) begin
                            j_next     = '0;
                            state_next = ST_V0;
                        end else begin
                            pos_next   = pos_reg - signed'({{(POS_W - PLEN_W){1'b0}}, mm1});
                            state_next = ST_LOOP;
                        end
                    end
                    default: state_next = ST_LOOP;
                endcase
            end
            ST_D: begin
                if (plen_reg == PLEN_W'(1)) begin
                    j_next     = '0;
                    state_next = ST_V0;
                end else begin
                    gpos_next  = pos_reg + POS_W'(1);
                    ret_next   = RET_E;
                    state_next = ST_G0;
                end
            end
            ST_V0: state_next = ST_V1;
            ST_V1: begin
                if (pat_rdata != t_rdata) begin
                    state_next = ST_H0;
                end else if (j_reg == mm1) begin
                    count_next = count_reg + COUNT_W'(1);
                    state_next = ST_H0;
                end else begin
                    j_next     = j_reg + PLEN_W'(1);
                    state_next = ST_V0;
                end
            end
            ST_H0: state_next = ST_H1;
            ST_H1: state_next = ST_H2;
            ST_H2: begin
                pos_next   = pos_reg - signed'({{(POS_W - SH_W){1'b0}}, sh_rdata});
                state_next = ST_LOOP;
            end
            ST_DONE: begin
                // wait for the output register to drain
                if (!m_valid_reg || m_tready) begin
                    out_count_next = count_reg;
                    out_ovf_next   = ovf_reg;
                    m_valid_next   = 1'b1;
                    plen_next      = '0;
                    tlen_next      = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // capture the low gram byte as it arrives
        if (state_reg == ST_G1) lo_next = t_rdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gb_reg      <= CFG_W'(GB_RESET);
            plen_reg    <= '0;
            tlen_reg    <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gb_reg      <= gb_next;
            plen_reg    <= plen_next;
            tlen_reg    <= tlen_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        gpos_reg      <= gpos_next;
        ret_reg       <= ret_next;
        j_reg         <= j_next;
        idx_reg       <= idx_next;
        lb_reg        <= lb_next;
        prev_reg      <= prev_next;
        lo_reg        <= lo_next;
        count_reg     <= count_next;
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
    end
endmodule
`default_nettype wire

### rtl/qfem_checker.sv
// Port-level checks of the exact match counter, bound to the top level.
`default_nettype none
module qfem_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);
    // a stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // padding bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:14] == 2'b00)
        else $error("nonzero padding in result");

    // a final text item starts a search that blocks input
    a_search_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && s_tlast |=> !s_tready)
        else $error("input not stalled during search");

    // a new result appears only at the end of a search
    a_result_after_search: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a search");
endmodule

bind qgram_filtered_exact_match_count qfem_checker u_qfem_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
